// File: src/tp4_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tp4_pkg
// Shared constants, field layout and channel expansion table for the
// packed 4bpp tile pixel decoder.
// ----------------------------------------------------------------------------
package tp4_pkg;

  // sheet and palette geometry
  localparam int PALETTE_COUNT = 16;
  localparam int TILE_LIMIT    = 320;
  localparam int TILES_ACROSS  = 32;
  localparam int TILE_PIXELS   = 8;

  // palette store: 16 palettes of 16 colors
  localparam int PAL_W         = 4;
  localparam int SLOT_W        = 4;
  localparam int STORE_ADDR_W  = PAL_W + SLOT_W;
  localparam int COLOR_W       = 15;

  // field widths
  localparam int TILE_W        = 9;
  localparam int OFFSET_W      = 5;
  localparam int BYTE_W        = 8;
  localparam int X_W           = 8;
  localparam int Y_W           = 7;
  localparam int ARGB_W        = 32;
  localparam int IN_DATA_W     = 48;
  localparam int OUT_DATA_W    = 80;

  // rows of pixels covered by the tile sheet
  localparam int Y_LIMIT = ((TILE_LIMIT + TILES_ACROSS - 1) / TILES_ACROSS) * TILE_PIXELS;

  typedef enum logic {
    OP_PAL_WRITE = 1'b0,
    OP_TILE_BYTE = 1'b1
  } opcode_t;

  // floor(v * 255 / 31) for a 5-bit channel
  localparam logic [7:0] EXPAND_LUT [32] = '{
    8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
    8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
    8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
    8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
  };

  function automatic logic [7:0] expand_chan(input logic [4:0] v);
    return EXPAND_LUT[v];
  endfunction

endpackage : tp4_pkg
`default_nettype wire

// File: src/tp4_palette_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tp4_palette_ram
// Palette store: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module tp4_palette_ram #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 15
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr_a,
  input  wire logic [ADDR_W-1:0] raddr_b,
  output logic      [DATA_W-1:0] rdata_a,
  output logic      [DATA_W-1:0] rdata_b
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule : tp4_palette_ram
`default_nettype wire

// File: src/tp4_argb_expand.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tp4_argb_expand
// Turns one 15-bit palette color into a 32-bit ARGB pixel.
// ----------------------------------------------------------------------------
module tp4_argb_expand (
  input  wire logic [tp4_pkg::COLOR_W-1:0] color,
  input  wire logic                        opaque,
  output logic      [tp4_pkg::ARGB_W-1:0]  argb
);

  logic [7:0] alpha;

  assign alpha = opaque ? 8'hFF : 8'h00;

  // red in the low color bits (to argb[23:16]), blue in the high color bits (to argb[7:0])
  assign argb = {alpha,
                 tp4_pkg::expand_chan(color[4:0]),
                 tp4_pkg::expand_chan(color[9:5]),
                 tp4_pkg::expand_chan(color[14:10])};

endmodule : tp4_argb_expand
`default_nettype wire

// File: src/tile_4bpp_palette_pixel_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tile_4bpp_palette_pixel_decoder
// Decodes packed 4bpp tile bytes into pairs of ARGB pixels with sheet
// coordinates, through a loadable store of 16 palettes of 15-bit colors.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  ---------+-----------+------------------------------------------------
//  in_*     | slave     | tuser opcode; tdata palette write or tile byte
//  out_*    | master    | tdata pixel_x, pixel_y, left_argb, right_argb
//  cfg_*    | write     | active_palette
//
//  Three register stages: input register, palette read (registered RAM
//  ports), output register. One item per clock while out_tready is high.
//  A palette write lands in the store as it leaves the input register, so
//  a tile byte right behind it already sees the new color.
//  Each stage holds under stall and takes new data once emptied or drained.
//  Reset clears the valid bits and the active palette; the store is
//  unknown until written.
// ----------------------------------------------------------------------------
module tile_4bpp_palette_pixel_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // slave request channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [3:0] palette_number, [7:4] color_index, [22:8] color_value,
  // [31:23] tile_index, [36:32] byte_offset, [44:37] tile_byte, rest zero
  input  wire logic [47:0] in_tdata,
  // [0] opcode
  input  wire logic        in_tuser,
  // master result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [7:0] pixel_x, [14:8] pixel_y, [46:15] left_argb, [78:47] right_argb,
  // [79] zero
  output logic [79:0]      out_tdata,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [3:0]  cfg_wdata
);

  localparam int AW = tp4_pkg::STORE_ADDR_W;
  localparam int CW = tp4_pkg::COLOR_W;

  // configuration register
  logic [tp4_pkg::PAL_W-1:0] active_pal_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_pal_r <= '0;
    end else if (cfg_we) begin
      active_pal_r <= cfg_wdata;
    end
  end

  // ---------------------------------------------------------------- ready
  logic s1_valid_r, s2_valid_r, out_valid_r;
  logic s1_ready, s2_ready, s3_ready;
  logic in_fire, s1_fire;

  assign s3_ready  = !out_valid_r || out_tready;
  assign s2_ready  = !s2_valid_r || s3_ready;
  assign s1_ready  = !s1_valid_r || s2_ready;
  assign in_tready = s1_ready;
  assign in_fire   = in_tvalid && in_tready;
  assign s1_fire   = s1_valid_r && s2_ready;

  // ---------------------------------------------------------- stage 1: input
  tp4_pkg::opcode_t                 s1_op_r;
  logic [tp4_pkg::PAL_W-1:0]        s1_pal_r;
  logic [tp4_pkg::SLOT_W-1:0]       s1_slot_r;
  logic [CW-1:0]                    s1_color_r;
  logic [tp4_pkg::TILE_W-1:0]       s1_tile_r;
  logic [tp4_pkg::OFFSET_W-1:0]     s1_off_r;
  logic [tp4_pkg::BYTE_W-1:0]       s1_byte_r;
  logic                             s1_valid_nxt;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_ready) begin
      s1_valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r    <= tp4_pkg::opcode_t'(in_tuser);
      s1_pal_r   <= in_tdata[3:0];
      s1_slot_r  <= in_tdata[7:4];
      s1_color_r <= in_tdata[22:8];
      s1_tile_r  <= in_tdata[31:23];
      s1_off_r   <= in_tdata[36:32];
      s1_byte_r  <= in_tdata[44:37];
    end
  end

  // ------------------------------------------- stage 1 -> 2: palette access
  logic          is_tile, is_write;
  logic          tile_ok, pal_ok, wr_ok;
  logic          mem_we, mem_re;
  logic [AW-1:0] waddr, raddr_l, raddr_r;
  logic [15:0]   x_wide, y_wide;

  assign is_tile  = (s1_op_r == tp4_pkg::OP_TILE_BYTE);
  assign is_write = (s1_op_r == tp4_pkg::OP_PAL_WRITE);
  assign tile_ok  = 32'(s1_tile_r) < 32'(tp4_pkg::TILE_LIMIT);
  assign pal_ok   = 32'(active_pal_r) < 32'(tp4_pkg::PALETTE_COUNT);
  assign wr_ok    = 32'(s1_pal_r) < 32'(tp4_pkg::PALETTE_COUNT);

  assign mem_we  = s1_fire && is_write && wr_ok;
  assign mem_re  = s1_fire && is_tile;
  assign waddr   = {s1_pal_r, s1_slot_r};
  assign raddr_l = {active_pal_r, s1_byte_r[3:0]};
  assign raddr_r = {active_pal_r, s1_byte_r[7:4]};

  assign x_wide = 16'((32'(s1_tile_r) % tp4_pkg::TILES_ACROSS) * tp4_pkg::TILE_PIXELS)
                + 16'({s1_off_r[1:0], 1'b0});
  assign y_wide = 16'((32'(s1_tile_r) / tp4_pkg::TILES_ACROSS) * tp4_pkg::TILE_PIXELS)
                + 16'(s1_off_r[4:2]);

  logic [CW-1:0] rd_l, rd_r;

  tp4_palette_ram #(
    .ADDR_W (AW),
    .DATA_W (CW)
  ) u_palette_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (waddr),
    .wdata   (s1_color_r),
    .re      (mem_re),
    .raddr_a (raddr_l),
    .raddr_b (raddr_r),
    .rdata_a (rd_l),
    .rdata_b (rd_r)
  );

  // ---------------------------------------------------- stage 2: read data
  logic                   s2_valid_nxt;
  logic [tp4_pkg::X_W-1:0] s2_x_r;
  logic [tp4_pkg::Y_W-1:0] s2_y_r;
  logic                   s2_opq_l_r, s2_opq_r_r;

  always_comb begin
    s2_valid_nxt = s2_valid_r;
    if (s2_ready) begin
      // drop writes and tiles off the sheet
      s2_valid_nxt = s1_valid_r && is_tile && tile_ok && pal_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      s2_x_r     <= x_wide[tp4_pkg::X_W-1:0];
      s2_y_r     <= y_wide[tp4_pkg::Y_W-1:0];
      s2_opq_l_r <= (s1_byte_r[3:0] != 4'd0);
      s2_opq_r_r <= (s1_byte_r[7:4] != 4'd0);
    end
  end

  // ------------------------------------------------ stage 3: expand, output
  logic [tp4_pkg::ARGB_W-1:0] argb_l, argb_r;

  tp4_argb_expand u_expand_l (
    .color  (rd_l),
    .opaque (s2_opq_l_r),
    .argb   (argb_l)
  );

  tp4_argb_expand u_expand_r (
    .color  (rd_r),
    .opaque (s2_opq_r_r),
    .argb   (argb_r)
  );

  logic                       out_valid_nxt;
  logic                       s2_fire;
  logic [tp4_pkg::X_W-1:0]    out_x_r;
  logic [tp4_pkg::Y_W-1:0]    out_y_r;
  logic [tp4_pkg::ARGB_W-1:0] out_l_r, out_r_r;

  assign s2_fire = s2_valid_r && s3_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s3_ready) begin
      out_valid_nxt = s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      out_x_r <= s2_x_r;
      out_y_r <= s2_y_r;
      out_l_r <= argb_l;
      out_r_r <= argb_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_r_r, out_l_r, out_y_r, out_x_r};

  // ------------------------------------------------------------- checks
  a_drop_no_result : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && (is_write || !tile_ok)) |=> !s2_valid_r)
    else $error("dropped request reached the read stage");

  a_s2_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !s3_ready) |=> (s2_valid_r && $stable(s2_x_r) && $stable(s2_y_r)
                                   && $stable(rd_l) && $stable(rd_r)))
    else $error("read stage changed while stalled");

  a_y_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (32'(out_y_r) < tp4_pkg::Y_LIMIT))
    else $error("pixel row beyond the sheet");

endmodule : tile_4bpp_palette_pixel_decoder
`default_nettype wire
